### src/gbdc_pkg.sv
package gbdc_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 16777216;

  // Pixel and result field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned BIN_W   = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THR = 1'd1;

  localparam logic [PIX_W-1:0] GRAY_THR_RST = 8'd128;
  localparam logic [PCT_W-1:0] DARK_THR_RST = 7'd50;

  // gray = floor((30R + 59G + 11B) / 100)
  localparam int unsigned SUM_W = 15;
  localparam logic [SUM_W-1:0] W_RED   = 15'd30;
  localparam logic [SUM_W-1:0] W_GREEN = 15'd59;
  localparam logic [SUM_W-1:0] W_BLUE  = 15'd11;

  // x / 100 == (x * 10486) >> 20 for all x < 25600
  localparam int unsigned RECIP_W    = 14;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam logic [PROD_W-1:0] GRAY_RECIP = 29'd10486;
  localparam int unsigned GRAY_SHIFT = 20;

  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned STEP_W     = $clog2(PCT_W);

  typedef struct packed {
    logic load;
    logic classify;
    logic div_init;
    logic div_step;
    logic finish;
  } gbdc_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } gbdc_stat_t;

endpackage

### src/gbdc_ctrl.sv
module gbdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  gbdc_pkg::gbdc_stat_t stat_i,
  output gbdc_pkg::gbdc_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GRAY  = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GRAY;
        end
      end
      S_GRAY: begin
        cmd_o.classify = 1'b1;
        state_d = stat_i.last ? S_DINIT : S_OUT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        // hand-over: next pixel may enter as this word leaves
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_GRAY;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### src/gbdc_dp.sv
module gbdc_dp #(
  parameter int unsigned MAX_PIXELS = gbdc_pkg::MAX_PIXELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gbdc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gbdc_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [gbdc_pkg::PIX_W-1:0]         blue_i,
  input  logic [gbdc_pkg::PIX_W-1:0]         green_i,
  input  logic [gbdc_pkg::PIX_W-1:0]         red_i,
  input  logic                               end_of_image_i,
  input  gbdc_pkg::gbdc_cmd_t                cmd_i,
  output gbdc_pkg::gbdc_stat_t               stat_o,
  output logic [gbdc_pkg::GRAY_W-1:0]        gray_level_o,
  output logic [gbdc_pkg::BIN_W-1:0]         binary_level_o,
  output logic [gbdc_pkg::PCT_W-1:0]         percent_black_o,
  output logic                               is_nearly_black_o,
  output logic                               verdict_valid_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned DEN_W = CNT_W + 1;
  localparam int unsigned REM_W = CNT_W + gbdc_pkg::PCT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [gbdc_pkg::PIX_W-1:0]  gthr_q;
  logic [gbdc_pkg::PCT_W-1:0]  dthr_q;
  logic [gbdc_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic                        last_q;
  logic [gbdc_pkg::PROD_W-1:0] prod;
  logic [gbdc_pkg::GRAY_W-1:0] gray_c;
  logic                        white_c;
  logic [CNT_W-1:0]            black_q, white_q;
  logic [CNT_W-1:0]            black_inc, white_inc;
  logic [REM_W-1:0]            rem_q, den_sh;
  logic [DEN_W-1:0]            den_q;
  logic [gbdc_pkg::PCT_W-1:0]  quo_q;
  logic [gbdc_pkg::STEP_W-1:0] step_q;
  logic [gbdc_pkg::GRAY_W-1:0] gray_q;
  logic                        bin_q;
  logic [gbdc_pkg::PCT_W-1:0]  pct_q;
  logic                        dark_q;
  logic                        verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gthr_q <= gbdc_pkg::GRAY_THR_RST;
      dthr_q <= gbdc_pkg::DARK_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbdc_pkg::REG_GRAY_THR: gthr_q <= cfg_data_i;
        gbdc_pkg::REG_DARK_THR: dthr_q <= cfg_data_i[gbdc_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // weighted sum straight from the ports, registered at accept
  always_comb begin
    sum_d = gbdc_pkg::SUM_W'(red_i)   * gbdc_pkg::W_RED
          + gbdc_pkg::SUM_W'(green_i) * gbdc_pkg::W_GREEN
          + gbdc_pkg::SUM_W'(blue_i)  * gbdc_pkg::W_BLUE;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q  <= sum_d;
      last_q <= end_of_image_i;
    end
  end

  assign prod    = gbdc_pkg::PROD_W'(sum_q) * gbdc_pkg::GRAY_RECIP;
  assign gray_c  = prod[gbdc_pkg::GRAY_SHIFT +: gbdc_pkg::GRAY_W];
  assign white_c = gray_c > gthr_q;

  // saturating counts
  assign black_inc = (black_q < CNT_MAX) ? black_q + 1'b1 : black_q;
  assign white_inc = (white_q < CNT_MAX) ? white_q + 1'b1 : white_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= '0;
      white_q <= '0;
    end else if (cmd_i.classify) begin
      if (white_c) begin
        white_q <= white_inc;
      end else begin
        black_q <= black_inc;
      end
    end else if (cmd_i.div_init) begin
      black_q <= '0;
      white_q <= '0;
    end
  end

  // restoring divider, one quotient bit per cycle, MSB first
  assign den_sh = REM_W'(den_q) << step_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= REM_W'(black_q) * REM_W'(gbdc_pkg::PCT_SCALE);
      den_q  <= DEN_W'(black_q) + DEN_W'(white_q);
      quo_q  <= '0;
      step_q <= gbdc_pkg::STEP_W'(gbdc_pkg::PCT_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_q >= den_sh) begin
        rem_q         <= rem_q - den_sh;
        quo_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 1'b1;
    end
  end

  assign stat_o.last     = last_q;
  assign stat_o.div_done = (step_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      gray_q    <= gray_c;
      bin_q     <= white_c;
      pct_q     <= '0;
      dark_q    <= 1'b0;
      verdict_q <= 1'b0;
    end else if (cmd_i.finish) begin
      pct_q     <= quo_q;
      dark_q    <= quo_q > dthr_q;
      verdict_q <= 1'b1;
    end
  end

  assign gray_level_o      = gray_q;
  assign binary_level_o    = {gbdc_pkg::BIN_W{bin_q}};
  assign percent_black_o   = pct_q;
  assign is_nearly_black_o = dark_q;
  assign verdict_valid_o   = verdict_q;

endmodule

### src/gray_binarize_dark_classify.sv
// Order: a word is ready once the gray/classify state has registered its pixel; for the pixel
//   marked end of image it follows gray, setup, the divider steps (one per quotient bit), finish.
// Flow: a new pixel is accepted only while idle or as the previous word leaves the output;
//   the last pixel of an image also holds the block in the divider.
// Reset (async, active low): counts cleared, thresholds to 128 and 50, block idle.
module gray_binarize_dark_classify #(
  parameter int unsigned MAX_PIXELS = gbdc_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [gbdc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbdc_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel in
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gbdc_pkg::PIX_W-1:0]     blue_i,
  input  logic [gbdc_pkg::PIX_W-1:0]     green_i,
  input  logic [gbdc_pkg::PIX_W-1:0]     red_i,
  input  logic                           end_of_image_i,
  // result out
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gbdc_pkg::GRAY_W-1:0]    gray_level_o,
  output logic [gbdc_pkg::BIN_W-1:0]     binary_level_o,
  output logic [gbdc_pkg::PCT_W-1:0]     percent_black_o,
  output logic                           is_nearly_black_o,
  output logic                           verdict_valid_o
);

  gbdc_pkg::gbdc_cmd_t  cmd;
  gbdc_pkg::gbdc_stat_t stat;

  // Sequencer: accept -> gray/classify -> (divide on last pixel) -> hold word
  gbdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: weighted sum, reciprocal /100, threshold, counters, divider,
  // output word registers
  gbdc_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .blue_i            (blue_i),
    .green_i           (green_i),
    .red_i             (red_i),
    .end_of_image_i    (end_of_image_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .gray_level_o      (gray_level_o),
    .binary_level_o    (binary_level_o),
    .percent_black_o   (percent_black_o),
    .is_nearly_black_o (is_nearly_black_o),
    .verdict_valid_o   (verdict_valid_o)
  );

  // A stalled word must not let a new pixel in
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("pixel accepted while output word stalled");

  // Binary level is all zeros or all ones
  a_bin_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (binary_level_o == '0 || binary_level_o == '1))
    else $error("binary level not 0 or 255");

  // Verdict fields are zero on ordinary pixels
  a_no_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !verdict_valid_o) |-> (percent_black_o == '0 && !is_nearly_black_o))
    else $error("verdict fields set on ordinary pixel");

  // Percent never above 100; nearly black implies some black
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_valid_o) |->
      (percent_black_o <= gbdc_pkg::PCT_W'(gbdc_pkg::PCT_SCALE) &&
       (!is_nearly_black_o || percent_black_o != '0)))
    else $error("percent black out of range");

endmodule
